@@ design/amt_pkg.sv @@
// amt_pkg: shared widths, step sizes, register indexes and direction codes
// for the adaptive migration threshold tuner and its checker.
// No dependencies.
package amt_pkg;

   localparam int THRESHOLD_WIDTH = 16;
   localparam int GAP_WIDTH       = 16;
   localparam int COUNT_WIDTH     = 32;
   localparam int MIG_WIDTH       = 40;
   localparam int PRODUCT_WIDTH   = COUNT_WIDTH + 1 + GAP_WIDTH;
   localparam int BENEFIT_WIDTH   = 52;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int STEP_WIDTH      = 2;
   localparam int MAX_STEP_DELTA  = 4;

   localparam logic [STEP_WIDTH-1:0]  BIG_STEP   = 2'd3;
   localparam logic [STEP_WIDTH-1:0]  SMALL_STEP = 2'd1;
   localparam logic [COUNT_WIDTH-1:0] INTERVAL_RESET = 32'd10000000;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_INITIAL_THRESHOLD,
      CSR_DIRTY_GAP,
      CSR_CLEAN_GAP,
      CSR_INTERVAL
   } csr_index_type;

   typedef enum logic [1:0] {
      DIR_INIT,
      DIR_INC,
      DIR_DEC
   } dir_type;

endpackage

@@ design/adaptive_migration_threshold.sv @@
// adaptive_migration_threshold: hill-climbing tuner for a page migration threshold.
// Depends on amt_pkg.
//
// Usage:
//  - req_ channel: one beat per memory event. req_action 0 is a completed request
//    (counts dirty or clean row misses to migrated pages), 1 is one clock tick
//    (counts cycles; when the count exceeds interval_length the threshold is
//    stepped using the benefit of migration and req_migration_cycles).
//  - rsp_ channel: exactly one beat per req_ beat, in order, carrying the
//    threshold and last step direction after that event, and rsp_adjusted when
//    the tick closed an interval.
//  - csr_ channel: always ready; index 0 initial threshold (also loads the
//    current threshold), 1 dirty gap, 2 clean gap, 3 interval length.
// Throughput: one beat per cycle while no result waits on rsp_ready. Path: an accepted beat
//  goes to the input register, then to the result register that drives rsp_valid;
//  the benefit multiplies, compare and threshold step sit between the two.
// Reset: clears counters, previous benefit, direction, registers to defaults.
// Stall: a waiting result holds; the input register still takes one more beat,
//  then req_ready drops until rsp_ready returns.
module adaptive_migration_threshold (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_action,
   input  logic                                 req_page_migrated,
   input  logic                                 req_row_hit,
   input  logic                                 req_dirty_writeback,
   input  logic [amt_pkg::MIG_WIDTH-1:0]        req_migration_cycles,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [amt_pkg::THRESHOLD_WIDTH-1:0]  rsp_threshold,
   output logic                                 rsp_adjusted,
   output logic [1:0]                           rsp_direction,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [amt_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [amt_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import amt_pkg::*;

   function automatic logic [THRESHOLD_WIDTH-1:0] raise_by(
      input logic [THRESHOLD_WIDTH-1:0] t,
      input logic [STEP_WIDTH-1:0]      n
   );
      logic [THRESHOLD_WIDTH:0] s;
      s = {1'b0, t} + {{(THRESHOLD_WIDTH+1-STEP_WIDTH){1'b0}}, n};
      return s[THRESHOLD_WIDTH] ? {THRESHOLD_WIDTH{1'b1}} : s[THRESHOLD_WIDTH-1:0];
   endfunction

   function automatic logic [THRESHOLD_WIDTH-1:0] lower_by_one(
      input logic [THRESHOLD_WIDTH-1:0] t
   );
      return (t != '0) ? t - 1'b1 : t;
   endfunction

   // handshake and pipeline control
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic advance, req_accept, s1_fire, csr_accept;

   // input register
   logic                 s1_action_ff;
   logic                 s1_page_migrated_ff;
   logic                 s1_row_hit_ff;
   logic                 s1_dirty_writeback_ff;
   logic [MIG_WIDTH-1:0] s1_migration_cycles_ff;

   // result register
   logic [THRESHOLD_WIDTH-1:0] rsp_threshold_ff;
   logic                       rsp_adjusted_ff, rsp_adjusted_in;
   dir_type                    rsp_direction_ff;

   // configuration
   logic [THRESHOLD_WIDTH-1:0]    init_thr_ff, init_thr_in;
   logic signed [GAP_WIDTH-1:0]   dirty_gap_ff, dirty_gap_in;
   logic signed [GAP_WIDTH-1:0]   clean_gap_ff, clean_gap_in;
   logic [COUNT_WIDTH-1:0]        interval_ff, interval_in;

   // tuner state
   logic [THRESHOLD_WIDTH-1:0]    thr_ff, thr_in;
   dir_type                       dir_ff, dir_in;
   logic signed [BENEFIT_WIDTH-1:0] prev_ff, prev_in;
   logic [COUNT_WIDTH-1:0]        dirty_cnt_ff, dirty_cnt_in;
   logic [COUNT_WIDTH-1:0]        clean_cnt_ff, clean_cnt_in;
   logic [COUNT_WIDTH-1:0]        cycles_ff, cycles_in;

   // datapath
   logic signed [PRODUCT_WIDTH-1:0] dirty_prod, clean_prod;
   logic signed [BENEFIT_WIDTH-1:0] benefit;
   logic                            gain, interval_done;
   logic [COUNT_WIDTH-1:0]          cycles_next;
   logic [THRESHOLD_WIDTH-1:0]      thr_mid, adj_thr;
   dir_type                         dir_mid, adj_dir;

   assign advance    = !rsp_valid_ff || rsp_ready;
   assign req_ready  = !s1_valid_ff || advance;
   assign req_accept = req_valid && req_ready;
   assign s1_fire    = s1_valid_ff && advance;
   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && !rsp_ready);

   // benefit of migration over the interval
   assign dirty_prod = $signed({1'b0, dirty_cnt_ff}) * dirty_gap_ff;
   assign clean_prod = $signed({1'b0, clean_cnt_ff}) * clean_gap_ff;
   assign benefit = BENEFIT_WIDTH'(dirty_prod) + BENEFIT_WIDTH'(clean_prod)
                  - $signed({{(BENEFIT_WIDTH-MIG_WIDTH){1'b0}}, s1_migration_cycles_ff});
   assign gain = benefit > prev_ff;

   assign cycles_next   = (cycles_ff == '1) ? cycles_ff : cycles_ff + 1'b1;
   assign interval_done = s1_action_ff && (cycles_next > interval_ff);

   always_comb begin
      thr_mid = thr_ff;
      dir_mid = dir_ff;
      adj_thr = thr_ff;
      adj_dir = dir_ff;
      if (dir_ff == DIR_INIT) begin
         if (benefit > 0) begin
            adj_dir = DIR_DEC;
            adj_thr = lower_by_one(thr_ff);
         end else begin
            adj_dir = DIR_INC;
            adj_thr = raise_by(thr_ff, BIG_STEP);
         end
      end else begin
         if (benefit < 0) begin
            thr_mid = raise_by(thr_ff, BIG_STEP);
            dir_mid = DIR_INC;
         end
         adj_thr = thr_mid;
         adj_dir = dir_mid;
         if (gain) begin
            if (dir_mid == DIR_INC) begin
               adj_thr = raise_by(thr_mid, SMALL_STEP);
            end else if (dir_mid == DIR_DEC) begin
               adj_thr = lower_by_one(thr_mid);
            end
         end else begin
            if (dir_mid == DIR_INC && thr_mid != '0) begin
               adj_thr = thr_mid - 1'b1;
               adj_dir = DIR_DEC;
            end else if (dir_mid == DIR_DEC) begin
               adj_thr = raise_by(thr_mid, SMALL_STEP);
               adj_dir = DIR_INC;
            end
         end
      end
   end

   always_comb begin
      thr_in          = thr_ff;
      dir_in          = dir_ff;
      prev_in         = prev_ff;
      dirty_cnt_in    = dirty_cnt_ff;
      clean_cnt_in    = clean_cnt_ff;
      cycles_in       = cycles_ff;
      init_thr_in     = init_thr_ff;
      dirty_gap_in    = dirty_gap_ff;
      clean_gap_in    = clean_gap_ff;
      interval_in     = interval_ff;
      rsp_adjusted_in = 1'b0;
      if (s1_fire) begin
         if (!s1_action_ff) begin
            if (s1_page_migrated_ff && !s1_row_hit_ff) begin
               if (s1_dirty_writeback_ff) begin
                  if (dirty_cnt_ff != '1) dirty_cnt_in = dirty_cnt_ff + 1'b1;
               end else begin
                  if (clean_cnt_ff != '1) clean_cnt_in = clean_cnt_ff + 1'b1;
               end
            end
         end else if (interval_done) begin
            cycles_in       = '0;
            thr_in          = adj_thr;
            dir_in          = adj_dir;
            prev_in         = benefit;
            rsp_adjusted_in = 1'b1;
         end else begin
            cycles_in = cycles_next;
         end
      end
      if (csr_accept) begin
         unique case (csr_index_type'(csr_index))
            CSR_INITIAL_THRESHOLD: begin
               init_thr_in = csr_wdata[THRESHOLD_WIDTH-1:0];
               thr_in      = csr_wdata[THRESHOLD_WIDTH-1:0];
            end
            CSR_DIRTY_GAP: dirty_gap_in = $signed(csr_wdata[GAP_WIDTH-1:0]);
            CSR_CLEAN_GAP: clean_gap_in = $signed(csr_wdata[GAP_WIDTH-1:0]);
            CSR_INTERVAL:  interval_in  = csr_wdata[COUNT_WIDTH-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         init_thr_ff  <= '0;
         dirty_gap_ff <= '0;
         clean_gap_ff <= '0;
         interval_ff  <= INTERVAL_RESET;
         thr_ff       <= '0;
         dir_ff       <= DIR_INIT;
         prev_ff      <= '0;
         dirty_cnt_ff <= '0;
         clean_cnt_ff <= '0;
         cycles_ff    <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         init_thr_ff  <= init_thr_in;
         dirty_gap_ff <= dirty_gap_in;
         clean_gap_ff <= clean_gap_in;
         interval_ff  <= interval_in;
         thr_ff       <= thr_in;
         dir_ff       <= dir_in;
         prev_ff      <= prev_in;
         dirty_cnt_ff <= dirty_cnt_in;
         clean_cnt_ff <= clean_cnt_in;
         cycles_ff    <= cycles_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_action_ff           <= req_action;
         s1_page_migrated_ff    <= req_page_migrated;
         s1_row_hit_ff          <= req_row_hit;
         s1_dirty_writeback_ff  <= req_dirty_writeback;
         s1_migration_cycles_ff <= req_migration_cycles;
      end
      if (advance) begin
         rsp_threshold_ff <= thr_in;
         rsp_adjusted_ff  <= rsp_adjusted_in;
         rsp_direction_ff <= dir_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_threshold = rsp_threshold_ff;
   assign rsp_adjusted  = rsp_adjusted_ff;
   assign rsp_direction = rsp_direction_ff;

endmodule

@@ design/amt_checker.sv @@
// amt_checker: port-level assertions for adaptive_migration_threshold,
// bound to the top level at the end of this file.
// Depends on amt_pkg.
module amt_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 req_action,
   input logic                                 req_page_migrated,
   input logic                                 req_row_hit,
   input logic                                 req_dirty_writeback,
   input logic [amt_pkg::MIG_WIDTH-1:0]        req_migration_cycles,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [amt_pkg::THRESHOLD_WIDTH-1:0]  rsp_threshold,
   input logic                                 rsp_adjusted,
   input logic [1:0]                           rsp_direction,
   input logic                                 csr_valid,
   input logic                                 csr_ready,
   input logic [amt_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input logic [amt_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import amt_pkg::*;

   logic [THRESHOLD_WIDTH-1:0] last_thr_ff, last_thr_in;
   logic [1:0]                 last_dir_ff, last_dir_in;
   logic                       seen_ff, seen_in;
   logic                       csr_seen_ff, csr_seen_in;
   logic                       rsp_beat, csr_beat, no_write;
   logic [THRESHOLD_WIDTH-1:0] step;

   assign rsp_beat = rsp_valid && rsp_ready;
   assign csr_beat = csr_valid && csr_ready;
   assign no_write = seen_ff && !csr_seen_ff && !csr_beat;
   assign step = (rsp_threshold > last_thr_ff) ? rsp_threshold - last_thr_ff
                                               : last_thr_ff - rsp_threshold;

   always_comb begin
      last_thr_in = last_thr_ff;
      last_dir_in = last_dir_ff;
      seen_in     = seen_ff;
      csr_seen_in = csr_seen_ff || csr_beat;
      if (rsp_beat) begin
         last_thr_in = rsp_threshold;
         last_dir_in = rsp_direction;
         seen_in     = 1'b1;
         csr_seen_in = csr_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= 1'b0;
         csr_seen_ff <= 1'b0;
      end else begin
         seen_ff     <= seen_in;
         csr_seen_ff <= csr_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      last_thr_ff <= last_thr_in;
      last_dir_ff <= last_dir_in;
   end

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_threshold)
         && $stable(rsp_adjusted) && $stable(rsp_direction))
      else $error("stalled rsp beat changed");

   // an adjustment always leaves a real direction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_adjusted |-> rsp_direction == DIR_INC || rsp_direction == DIR_DEC)
      else $error("adjusted beat with init direction");

   // without an adjustment or a register write the threshold and direction stay
   assert property (@(posedge clock) disable iff (reset)
      rsp_beat && !rsp_adjusted && no_write |->
         rsp_threshold == last_thr_ff && rsp_direction == last_dir_ff)
      else $error("threshold moved without adjustment");

   // one adjustment moves the threshold by at most MAX_STEP_DELTA (4)
   assert property (@(posedge clock) disable iff (reset)
      rsp_beat && rsp_adjusted && no_write |-> step <= THRESHOLD_WIDTH'(MAX_STEP_DELTA))
      else $error("threshold step too large");

endmodule

bind adaptive_migration_threshold amt_checker u_amt_checker (.*);
